>>> rtl/single_precision_add_sub_mul_div_unit_macros.svh
// Assertion macros shared by the single-precision arithmetic unit.
`ifndef SINGLE_PRECISION_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH
`define SINGLE_PRECISION_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SPASMD_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("spasmd: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define SPASMD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("spasmd: next-cycle check failed");

`endif

>>> rtl/spasmd_pkg.sv
// Types and constants shared by the single-precision arithmetic unit.
`default_nettype none
package spasmd_pkg;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    localparam int NumCells = 32;

    localparam logic [10:0] ExpBias = 11'd127;

    // One transaction in flight through the cell chain
    typedef struct packed {
        kind_t              op;
        logic               sign;
        logic signed [10:0] expo;
        logic               zero;
        logic [47:0]        acc;
        logic [24:0]        rem;
        logic [23:0]        dvs;
    } item_t;

endpackage
`default_nettype wire

>>> rtl/spasmd_front.sv
// Entry stage: operand decode, add alignment, significand multiply, divide setup.
`default_nettype none
module spasmd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         kind,
    input  wire logic [31:0]        operand_a,
    input  wire logic [31:0]        operand_b,
    input  wire logic               next_free,
    output logic                    valid,
    output spasmd_pkg::item_t       item,
    output logic                    free
);
    import spasmd_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    kind_t       op;
    logic [31:0] b_eff;
    logic        swap;
    logic [31:0] x_op;
    logic [31:0] y_op;
    logic [7:0]  dexp;
    logic [30:0] ma_al;
    logic [30:0] mb_al;
    logic [30:0] mb_sh;
    logic [31:0] fsum;
    logic [23:0] ma;
    logic [23:0] mb;

    assign op    = kind_t'(kind);
    assign free  = !valid_reg || next_free;
    assign valid = valid_reg;
    assign item  = item_reg;

    // Align the smaller magnitude and add or subtract
    always_comb
    begin
        b_eff = (op == KIND_SUB) ? (operand_b ^ 32'h8000_0000) : operand_b;
        swap  = operand_a[30:0] < b_eff[30:0];
        x_op  = swap ? b_eff : operand_a;
        y_op  = swap ? operand_a : b_eff;
        dexp  = x_op[30:23] - y_op[30:23];
        ma_al = {1'b1, x_op[22:0], 7'b0};
        mb_al = {1'b1, y_op[22:0], 7'b0};
        mb_sh = (dexp >= 8'd31) ? 31'd0 : (mb_al >> dexp);
        if (x_op[31] == y_op[31])
        begin
            fsum = {1'b0, ma_al} + {1'b0, mb_sh};
        end
        else
        begin
            fsum = {1'b0, ma_al} - {1'b0, mb_sh};
        end
    end

    // Build the transaction for the chain
    always_comb
    begin
        ma        = {1'b1, operand_a[22:0]};
        mb        = {1'b1, operand_b[22:0]};
        item_next = '0;
        item_next.op = op;
        unique case (op)
            KIND_ADD, KIND_SUB:
            begin
                item_next.sign = x_op[31];
                item_next.zero = (fsum == 32'd0);
                if (fsum == 32'd0)
                begin
                    item_next.expo = 11'sd0;
                    item_next.acc  = 48'd0;
                end
                else if (fsum[31])
                begin
                    item_next.expo = $signed({3'b0, x_op[30:23]}) + 11'sd1;
                    item_next.acc  = {16'b0, 1'b0, fsum[31:1]};
                end
                else
                begin
                    item_next.expo = $signed({3'b0, x_op[30:23]});
                    item_next.acc  = {16'b0, fsum};
                end
            end
            KIND_MUL:
            begin
                item_next.sign = operand_a[31] ^ operand_b[31];
                item_next.expo = $signed({3'b0, operand_a[30:23]} + {3'b0, operand_b[30:23]}
                                 - ExpBias);
                item_next.acc  = ma * mb;
            end
            KIND_DIV:
            begin
                item_next.sign = operand_a[31] ^ operand_b[31];
                item_next.expo = $signed({3'b0, operand_a[30:23]} - {3'b0, operand_b[30:23]}
                                 + ExpBias);
                item_next.rem  = {1'b0, ma};
                item_next.dvs  = mb;
            end
            default:
            begin
            end
        endcase
    end

    // Advance when the first cell has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/spasmd_cell.sv
// One chain cell: a restoring divide step or a one-bit normalizing left shift.
`default_nettype none
`include "single_precision_add_sub_mul_div_unit_macros.svh"
module spasmd_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               prev_valid,
    input  wire spasmd_pkg::item_t  prev_item,
    input  wire logic               next_free,
    output logic                    valid,
    output spasmd_pkg::item_t       item,
    output logic                    free
);
    import spasmd_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic        qbit;
    logic [24:0] rdiff;

    assign free  = !valid_reg || next_free;
    assign valid = valid_reg;
    assign item  = item_reg;

    // Resolve one quotient bit or one normalization shift
    always_comb
    begin
        item_next = prev_item;
        qbit      = (prev_item.rem >= {1'b0, prev_item.dvs});
        rdiff     = qbit ? (prev_item.rem - {1'b0, prev_item.dvs}) : prev_item.rem;
        unique case (prev_item.op)
            KIND_DIV:
            begin
                item_next.rem = {rdiff[23:0], 1'b0};
                item_next.acc = {prev_item.acc[46:0], qbit};
            end
            KIND_ADD, KIND_SUB:
            begin
                if (!prev_item.zero && !prev_item.acc[30])
                begin
                    item_next.acc  = {prev_item.acc[46:0], 1'b0};
                    item_next.expo = prev_item.expo - 11'sd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold while the next cell is full, else advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && prev_valid)
        begin
            item_reg <= item_next;
        end
    end

    `SPASMD_ASSERT_NOW(a_div_rem_bound, clk, rst_n,
        valid_reg && item_reg.op == KIND_DIV,
        item_reg.rem < {item_reg.dvs, 1'b0})
    `SPASMD_ASSERT_NOW(a_add_norm_range, clk, rst_n,
        valid_reg && (item_reg.op == KIND_ADD || item_reg.op == KIND_SUB) && !item_reg.zero,
        !item_reg.acc[31] && item_reg.acc[30:0] != 31'd0)
    `SPASMD_ASSERT_NEXT(a_hold_when_blocked, clk, rst_n,
        valid_reg && !next_free,
        valid_reg && $stable(item_reg))

endmodule
`default_nettype wire

>>> rtl/spasmd_back.sv
// Exit stage: rounding, final normalization, packing and the output register.
`default_nettype none
module spasmd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               prev_valid,
    input  wire spasmd_pkg::item_t  prev_item,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic [31:0]             result_word,
    output logic                    range_error,
    output logic                    free
);
    import spasmd_pkg::*;

    logic               valid_reg;
    logic [31:0]        word_reg;
    logic               flag_reg;
    logic [31:0]        word_next;
    logic               flag_next;
    logic signed [10:0] e_fin;
    logic [22:0]        frac;
    logic [31:0]        f_add;
    logic [31:0]        q_div;
    logic               hi;
    logic               carry;
    logic [48:0]        p_rnd;

    assign free        = !valid_reg || !out_stall;
    assign out_valid   = valid_reg;
    assign result_word = word_reg;
    assign range_error = flag_reg;

    // Round and pack per operation
    always_comb
    begin
        f_add = prev_item.acc[31:0] + {25'b0, prev_item.acc[6], 6'b0};
        q_div = prev_item.acc[31:0];
        hi    = prev_item.acc[47];
        p_rnd = hi ? ({1'b0, prev_item.acc} + {25'b0, prev_item.acc[23], 23'b0})
                   : ({1'b0, prev_item.acc} + {26'b0, prev_item.acc[22], 22'b0});
        carry = hi ? p_rnd[48] : p_rnd[47];
        e_fin = prev_item.expo;
        frac  = '0;
        unique case (prev_item.op)
            KIND_ADD, KIND_SUB:
            begin
                if (f_add[31])
                begin
                    frac  = f_add[30:8];
                    e_fin = prev_item.expo + 11'sd1;
                end
                else
                begin
                    frac = f_add[29:7];
                end
            end
            KIND_MUL:
            begin
                e_fin = prev_item.expo + $signed({10'b0, hi}) + $signed({10'b0, carry});
                priority if (hi && carry)
                begin
                    frac = p_rnd[47:25];
                end
                else if (hi || carry)
                begin
                    frac = p_rnd[46:24];
                end
                else
                begin
                    frac = p_rnd[45:23];
                end
            end
            KIND_DIV:
            begin
                if (q_div[31])
                begin
                    frac = q_div[30:8];
                end
                else
                begin
                    frac  = q_div[29:7];
                    e_fin = prev_item.expo - 11'sd1;
                end
            end
            default:
            begin
            end
        endcase
        word_next = {prev_item.sign, e_fin[7:0], frac};
        flag_next = (e_fin[10:8] != 3'b000);
    end

    // Load the output register when the consumer has taken the last transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && prev_valid)
        begin
            word_reg <= word_next;
            flag_reg <= flag_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/single_precision_add_sub_mul_div_unit.sv
// Top level of the single-precision add / subtract / multiply / divide unit.
// Accepts one transaction per clock and delivers one result per clock when the
// output is not stalled. A transaction passes through one entry stage
// (alignment and add, the 24x24 significand multiply, or divide setup), a
// chain of 32 cells that each resolve one quotient bit or one normalizing
// left shift, and one rounding stage that is the output register. Stages
// carry their own valid bit and move forward whenever the stage ahead has
// room, so bubbles collapse and the input keeps accepting while a finished
// result waits at the output.
`default_nettype none
module single_precision_add_sub_mul_div_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_word,
    output logic             range_error
);
    import spasmd_pkg::*;

    logic  chain_valid [NumCells+1];
    item_t chain_item  [NumCells+1];
    logic  chain_free  [NumCells+2];

    assign in_stall = !chain_free[0];

    // Entry stage
    spasmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .next_free (chain_free[1]),
        .valid     (chain_valid[0]),
        .item      (chain_item[0]),
        .free      (chain_free[0])
    );

    // Chain of cells
    for (genvar gi = 0; gi < NumCells; gi++)
    begin : g_cell
        spasmd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (chain_valid[gi]),
            .prev_item  (chain_item[gi]),
            .next_free  (chain_free[gi+2]),
            .valid      (chain_valid[gi+1]),
            .item       (chain_item[gi+1]),
            .free       (chain_free[gi+1])
        );
    end

    // Rounding and output register
    spasmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .prev_valid  (chain_valid[NumCells]),
        .prev_item   (chain_item[NumCells]),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .result_word (result_word),
        .range_error (range_error),
        .free        (chain_free[NumCells+1])
    );

endmodule
`default_nettype wire
